FILE: rtl/multi_camera_trigger_sequencer_top_defines.svh
// assertion macros for the trigger sequencer
`ifndef MULTI_CAMERA_TRIGGER_SEQUENCER_TOP_DEFINES_SVH
`define MULTI_CAMERA_TRIGGER_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MCTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mcts_pkg.sv
// types, constants and helpers shared by the trigger sequencer modules
package mcts_pkg;

    localparam int NUM_CAMERAS_DEF = 5;
    localparam int CAM_LINES       = 5;
    localparam int TICK_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CAM_IDX_W       = 3;
    localparam int PHASE_W         = 4;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic [TICK_W-1:0] RST_STARTUP_HOLD = 16'd3000;
    localparam logic [TICK_W-1:0] RST_PULSE        = 16'd100;
    localparam logic [TICK_W-1:0] RST_SETTLE       = 16'd2000;
    localparam logic [TICK_W-1:0] RST_STAGGER      = 16'd500;
    localparam logic [TICK_W-1:0] RST_GUARD        = 16'd200;
    localparam logic [TICK_W-1:0] RST_RESP_TIMEOUT = 16'd1000;
    localparam logic [TICK_W-1:0] RST_TRIG_MIN     = 16'd1700;
    localparam logic [TICK_W-1:0] RST_TRIG_MAX     = 16'd2000;

    typedef enum logic [PHASE_W-1:0] {
        PH_HOLD          = 4'd0,
        PH_JOINT_PULSE   = 4'd1,
        PH_SETTLE        = 4'd2,
        PH_STAGGER_GAP   = 4'd3,
        PH_STAGGER_PULSE = 4'd4,
        PH_FINAL_GAP     = 4'd5,
        PH_ARMED         = 4'd6,
        PH_CAPTURE       = 4'd7,
        PH_RECORD        = 4'd8,
        PH_WAIT_END      = 4'd9
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STARTUP_HOLD = 3'd0,
        CFG_PULSE        = 3'd1,
        CFG_SETTLE       = 3'd2,
        CFG_STAGGER      = 3'd3,
        CFG_GUARD        = 3'd4,
        CFG_RESP_TIMEOUT = 3'd5,
        CFG_TRIG_MIN     = 3'd6,
        CFG_TRIG_MAX     = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        REP_STARTUP = 1'b0,
        REP_CAPTURE = 1'b1
    } t_rep_kind;

    typedef struct packed {
        logic [TICK_W-1:0] startup_hold_ticks;
        logic [TICK_W-1:0] pulse_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] stagger_ticks;
        logic [TICK_W-1:0] guard_ticks;
        logic [TICK_W-1:0] response_timeout_ticks;
        logic [TICK_W-1:0] trig_width_min;
        logic [TICK_W-1:0] trig_width_max;
    } t_cfg;

    typedef struct packed {
        logic [CAM_LINES-1:0] shutter_drive;
        logic [PHASE_W-1:0]   phase;
        logic                 report_valid;
        logic                 report_kind;
        logic [CAM_LINES-1:0] report_flags;
    } t_result;

    // cameras beyond the physical lines are stepped through but never driven
    function automatic logic [CAM_LINES-1:0] cam_mask(input int n);
        return CAM_LINES'(((1 << n) - 1) & ((1 << CAM_LINES) - 1));
    endfunction

    function automatic logic [CAM_LINES-1:0] cam_bit(input logic [CAM_IDX_W-1:0] idx);
        logic [CAM_LINES-1:0] bit_sel;
        bit_sel = '0;
        if (32'(idx) < CAM_LINES) begin
            bit_sel = CAM_LINES'(1) << idx;
        end
        return bit_sel;
    endfunction

endpackage

FILE: rtl/multi_camera_trigger_sequencer_top.sv
// a tick transfer is first taken into the input register, then stepped through the
//   phase logic into the result register once that register frees up
// throughput: one tick transfer per cycle unless the result channel stalls, set by
//   one input register feeding one step of the phase logic into the result register
// the input stage takes a new tick while a finished result still waits downstream
// reset (synchronous, active low): phase to startup hold, counters, drive and
//   answer flags cleared, configuration back to its defaults, both stages empty
`include "multi_camera_trigger_sequencer_top_defines.svh"

module multi_camera_trigger_sequencer_top
    import mcts_pkg::*;
#(
    parameter int NUM_CAMERAS = NUM_CAMERAS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data,
    // tick channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TICK_W-1:0]    i_trig_width,
    input  logic [CAM_LINES-1:0] i_cam_answer,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CAM_LINES-1:0] o_shutter_drive,
    output logic [PHASE_W-1:0]   o_phase,
    output logic                 o_report_valid,
    output logic                 o_report_kind,
    output logic [CAM_LINES-1:0] o_report_flags
);

    localparam logic [CAM_LINES-1:0] CamMask = cam_mask(NUM_CAMERAS);

    t_cfg                 cfg;
    t_result              step_result;

    // input stage
    logic                 r_in_valid;
    logic [TICK_W-1:0]    r_trig_width;
    logic [CAM_LINES-1:0] r_cam_answer;

    // result stage
    logic                 r_out_valid;
    t_result              r_result;

    logic                 advance;

    // the held tick steps the sequencer whenever the result register frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    mcts_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mcts_core #(
        .NUM_CAMERAS (NUM_CAMERAS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_trig_width (r_trig_width),
        .i_cam_answer (r_cam_answer),
        .i_cfg        (cfg),
        .o_result     (step_result)
    );

    // input register: control reset, payload loaded on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_trig_width <= i_trig_width;
            r_cam_answer <= i_cam_answer;
        end
    end

    // result register: filled on each step, emptied on transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_shutter_drive = r_result.shutter_drive;
    assign o_phase         = r_result.phase;
    assign o_report_valid  = r_result.report_valid;
    assign o_report_kind   = r_result.report_kind;
    assign o_report_flags  = r_result.report_flags;

    // reports only come out of the last staggered pulse or the record step
    `MCTS_ASSERT_NOW(a_report_phase, o_out_valid && o_report_valid, (o_phase == PH_FINAL_GAP) || (o_phase == PH_WAIT_END), "report outside final gap or wait-end phase")
    // a capture record always lands in the wait-for-trigger-end phase
    `MCTS_ASSERT_NOW(a_capture_kind, o_out_valid && (o_report_kind == REP_CAPTURE), o_report_valid && (o_phase == PH_WAIT_END), "capture record kind without a capture report")
    // shutters of absent cameras are never pulled
    `MCTS_ASSERT_NOW(a_drive_mask, o_out_valid, (o_shutter_drive & ~CamMask) == '0, "shutter driven outside the camera mask")
    // a stalled result with a waiting tick keeps the tick held in the input stage
    `MCTS_ASSERT_NEXT(a_in_hold, r_in_valid && r_out_valid && !i_out_ready, r_in_valid, "input stage dropped a tick while stalled")

endmodule

FILE: rtl/mcts_cfg_regs.sv
// configuration register file of the trigger sequencer
module mcts_cfg_regs
    import mcts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_hold_ticks     <= RST_STARTUP_HOLD;
            r_cfg.pulse_ticks            <= RST_PULSE;
            r_cfg.settle_ticks           <= RST_SETTLE;
            r_cfg.stagger_ticks          <= RST_STAGGER;
            r_cfg.guard_ticks            <= RST_GUARD;
            r_cfg.response_timeout_ticks <= RST_RESP_TIMEOUT;
            r_cfg.trig_width_min         <= RST_TRIG_MIN;
            r_cfg.trig_width_max         <= RST_TRIG_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STARTUP_HOLD: r_cfg.startup_hold_ticks     <= i_cfg_data;
                CFG_PULSE:        r_cfg.pulse_ticks            <= i_cfg_data;
                CFG_SETTLE:       r_cfg.settle_ticks           <= i_cfg_data;
                CFG_STAGGER:      r_cfg.stagger_ticks          <= i_cfg_data;
                CFG_GUARD:        r_cfg.guard_ticks            <= i_cfg_data;
                CFG_RESP_TIMEOUT: r_cfg.response_timeout_ticks <= i_cfg_data;
                CFG_TRIG_MIN:     r_cfg.trig_width_min         <= i_cfg_data;
                CFG_TRIG_MAX:     r_cfg.trig_width_max         <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/mcts_core.sv
// sequencer state and per-tick step logic
module mcts_core
    import mcts_pkg::*;
#(
    parameter int NUM_CAMERAS = NUM_CAMERAS_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [TICK_W-1:0]    i_trig_width,
    input  logic [CAM_LINES-1:0] i_cam_answer,
    input  t_cfg                 i_cfg,
    output t_result              o_result
);

    localparam logic [CAM_LINES-1:0]   CamMask = cam_mask(NUM_CAMERAS);
    localparam logic [CAM_IDX_W:0]     CamCount = (CAM_IDX_W+1)'(NUM_CAMERAS);

    t_phase               r_phase, n_phase;
    logic [TICK_W-1:0]    r_elapsed, n_elapsed;
    logic [CAM_IDX_W-1:0] r_cam_index, n_cam_index;
    logic [CAM_LINES-1:0] r_cam_active, n_cam_active;
    logic [CAM_LINES-1:0] r_answered, n_answered;
    logic [CAM_LINES-1:0] r_drive, n_drive;

    logic                 rep_valid;
    logic                 rep_kind;
    logic [CAM_LINES-1:0] rep_flags;

    logic [TICK_W-1:0]    elapsed_inc;
    logic                 hold_done, pulse_done, settle_done, stagger_done;
    logic                 in_win, trig_ok, timed_out;
    logic [CAM_IDX_W:0]   stag_next;
    logic                 stag_last;
    logic [CAM_LINES-1:0] cur_bit, hit, rest;

    // saturating tick count, then the per-phase conditions
    assign elapsed_inc  = (r_elapsed != TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign hold_done    = elapsed_inc >= i_cfg.startup_hold_ticks;
    assign pulse_done   = elapsed_inc >= i_cfg.pulse_ticks;
    assign settle_done  = elapsed_inc >= i_cfg.settle_ticks;
    assign stagger_done = elapsed_inc >= i_cfg.stagger_ticks;
    assign timed_out    = elapsed_inc >= i_cfg.response_timeout_ticks;
    assign in_win       = (i_trig_width >= i_cfg.trig_width_min) &&
                          (i_trig_width <= i_cfg.trig_width_max);
    assign trig_ok      = (elapsed_inc > i_cfg.guard_ticks) && in_win;
    assign stag_next    = {1'b0, r_cam_index} + {{CAM_IDX_W{1'b0}}, pulse_done};
    assign stag_last    = stag_next >= CamCount;
    assign cur_bit      = cam_bit(r_cam_index);
    assign hit          = r_cam_active & i_cam_answer;
    assign rest         = r_cam_active & ~i_cam_answer;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HOLD:          if (hold_done) n_phase = PH_JOINT_PULSE;
            PH_JOINT_PULSE:   if (pulse_done) n_phase = PH_SETTLE;
            PH_SETTLE:        if (settle_done) n_phase = PH_STAGGER_GAP;
            PH_STAGGER_GAP:   if (stagger_done) n_phase = PH_STAGGER_PULSE;
            PH_STAGGER_PULSE: begin
                if (stag_last) begin
                    n_phase = PH_FINAL_GAP;
                end else if (pulse_done) begin
                    n_phase = PH_STAGGER_GAP;
                end
            end
            PH_FINAL_GAP:     if (stagger_done) n_phase = PH_ARMED;
            PH_ARMED:         if (trig_ok) n_phase = PH_CAPTURE;
            PH_CAPTURE:       if (r_cam_active == '0) n_phase = PH_RECORD;
            PH_RECORD:        n_phase = PH_WAIT_END;
            PH_WAIT_END:      if (!in_win) n_phase = PH_ARMED;
            default:          n_phase = r_phase;
        endcase
    end

    // datapath and report outputs
    always_comb begin
        n_elapsed    = elapsed_inc;
        n_cam_index  = r_cam_index;
        n_cam_active = r_cam_active;
        n_answered   = r_answered;
        n_drive      = r_drive;
        rep_valid    = 1'b0;
        rep_kind     = REP_STARTUP;
        rep_flags    = '0;
        unique case (r_phase)
            PH_HOLD: begin
                if (hold_done) begin
                    n_drive   = CamMask;
                    n_elapsed = '0;
                end
            end
            PH_JOINT_PULSE: begin
                if (pulse_done) begin
                    n_drive   = '0;
                    n_elapsed = '0;
                end
            end
            PH_SETTLE: begin
                if (settle_done) begin
                    n_elapsed   = '0;
                    n_cam_index = '0;
                end
            end
            PH_STAGGER_GAP: begin
                if (stagger_done) begin
                    n_drive   = r_drive | cur_bit;
                    n_elapsed = '0;
                end
            end
            PH_STAGGER_PULSE: begin
                // feedback only sampled while the pulse is still running
                if (pulse_done) begin
                    n_drive   = r_drive & ~cur_bit;
                    n_elapsed = '0;
                end else if ((i_cam_answer & cur_bit) != '0) begin
                    n_answered = r_answered | cur_bit;
                end
                n_cam_index = stag_next[CAM_IDX_W-1:0];
                if (stag_last) begin
                    rep_valid  = 1'b1;
                    rep_kind   = REP_STARTUP;
                    rep_flags  = n_answered;
                    n_answered = '0;
                    n_elapsed  = '0;
                end
            end
            PH_FINAL_GAP: begin
                if (stagger_done) begin
                    n_elapsed = '0;
                end
            end
            PH_ARMED: begin
                if (trig_ok) begin
                    n_cam_index  = '0;
                    n_cam_active = CamMask;
                    n_drive      = CamMask;
                    n_elapsed    = '0;
                end
            end
            PH_CAPTURE: begin
                if (r_cam_active != '0) begin
                    // answers release first, the timeout drops the rest unanswered
                    n_answered   = r_answered | hit;
                    n_drive      = r_drive & ~hit;
                    n_cam_active = r_cam_active & ~hit;
                    if (timed_out) begin
                        n_answered   = n_answered & ~rest;
                        n_drive      = n_drive & ~rest;
                        n_cam_active = n_cam_active & ~rest;
                    end
                end
            end
            PH_RECORD: begin
                rep_valid  = 1'b1;
                rep_kind   = REP_CAPTURE;
                rep_flags  = r_answered;
                n_answered = '0;
                n_elapsed  = '0;
            end
            PH_WAIT_END: begin
                n_elapsed = elapsed_inc;
            end
            default: begin
                n_elapsed = elapsed_inc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HOLD;
            r_elapsed    <= '0;
            r_cam_index  <= '0;
            r_cam_active <= '0;
            r_answered   <= '0;
            r_drive      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_elapsed    <= n_elapsed;
            r_cam_index  <= n_cam_index;
            r_cam_active <= n_cam_active;
            r_answered   <= n_answered;
            r_drive      <= n_drive;
        end
    end

    assign o_result.shutter_drive = n_drive;
    assign o_result.phase         = PHASE_W'(n_phase);
    assign o_result.report_valid  = rep_valid;
    assign o_result.report_kind   = rep_kind;
    assign o_result.report_flags  = rep_flags;

endmodule
